FILE: hw/rtl/qcf_pkg.sv
// qcf_pkg: shared types and constants for the quadratic curve flattener
// no dependencies; imported by every module of the block

package qcf_pkg;

    // default configuration
    localparam int MAX_LEVEL_DEF   = 6;
    localparam int LEAF_LEVEL_DEF  = 5;
    localparam int QUEUE_DEPTH_DEF = 2;

    // field widths
    localparam int COORD_W  = 32;
    localparam int POINT_W  = 26;
    localparam int LVL_W    = 3;
    localparam int FIXED_W  = 4;
    localparam int COUNT_W  = 16;
    localparam int STEP_W   = 7;
    localparam int SHIFT_W  = 4;

    // arithmetic constants
    localparam int AUTO_SHIFT = 10;
    localparam logic [31:0] FLAT_LIMIT = 32'd128;
    localparam logic [31:0] ROUND_ADD  = 32'd3;
    localparam int OUT_SHIFT = 6;
    localparam logic [15:0] CAP_RESET = 16'd257;

    typedef logic signed [COORD_W-1:0] coord_t;

    // start, control and end point of one curve
    typedef struct packed {
        coord_t ax;
        coord_t ay;
        coord_t bx;
        coord_t by;
        coord_t cx;
        coord_t cy;
    } curve_t;

    // one classified curve handed from front to back
    typedef struct packed {
        curve_t           crv;
        logic [LVL_W-1:0] lvl;
        logic             ovf;
    } job_t;

endpackage

FILE: hw/rtl/qcf_front.sv
// qcf_front: accepts curves, picks the level and checks the vector count
// depends on qcf_pkg

module qcf_front #(
    parameter int MAX_LEVEL = qcf_pkg::MAX_LEVEL_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  qcf_pkg::coord_t                       start_x,
    input  qcf_pkg::coord_t                       start_y,
    input  qcf_pkg::coord_t                       ctrl_x,
    input  qcf_pkg::coord_t                       ctrl_y,
    input  qcf_pkg::coord_t                       end_x,
    input  qcf_pkg::coord_t                       end_y,
    input  logic signed [qcf_pkg::FIXED_W-1:0]    fixed_level,
    input  logic                                  clear_count,
    input  logic                                  cfg_we,
    input  logic [qcf_pkg::COUNT_W-1:0]           cfg_wdata,
    output logic                                  job_valid,
    input  logic                                  job_ready,
    output qcf_pkg::job_t                         job
);
    import qcf_pkg::*;

    localparam logic [2:0] F_IDLE = 3'd0;
    localparam logic [2:0] F_DD   = 3'd1;
    localparam logic [2:0] F_MEAS = 3'd2;
    localparam logic [2:0] F_LVL  = 3'd3;
    localparam logic [2:0] F_CNT  = 3'd4;
    localparam logic [2:0] F_PUSH = 3'd5;

    localparam logic [LVL_W-1:0] MAX_LVL = LVL_W'(MAX_LEVEL);

    logic [2:0]         st_reg, st_next;
    curve_t             crv_reg, crv_next;
    logic [LVL_W-1:0]   lvl_reg, lvl_next;
    logic               ovf_reg, ovf_next;
    logic [31:0]        ddx_reg, ddx_next, ddy_reg, ddy_next;
    logic [31:0]        meas_reg, meas_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [COUNT_W-1:0] cap_reg;

    logic               accept;
    logic [31:0]        mx, my;
    logic [COUNT_W:0]   sum;
    logic [FIXED_W-2:0] fl_mag;

    assign in_ready  = (st_reg == F_IDLE);
    assign accept    = in_valid && in_ready;
    assign job_valid = (st_reg == F_PUSH);
    assign job.crv   = crv_reg;
    assign job.lvl   = lvl_reg;
    assign job.ovf   = ovf_reg;

    assign mx     = ddx_reg[31] ? (32'd0 - ddx_reg) : ddx_reg;
    assign my     = ddy_reg[31] ? (32'd0 - ddy_reg) : ddy_reg;
    assign sum    = {1'b0, count_reg} + ((COUNT_W+1)'(1) << lvl_reg);
    assign fl_mag = fixed_level[FIXED_W-2:0];

    // classification sequence
    always_comb
    begin
        st_next    = st_reg;
        crv_next   = crv_reg;
        lvl_next   = lvl_reg;
        ovf_next   = ovf_reg;
        ddx_next   = ddx_reg;
        ddy_next   = ddy_reg;
        meas_next  = meas_reg;
        count_next = count_reg;
        case (st_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    ovf_next = 1'b0;
                    if (clear_count)
                        count_next = '0;
                    if (fixed_level[FIXED_W-1])
                    begin
                        // automatic mode: 16.16 down to 26.6
                        crv_next.ax = start_x >>> AUTO_SHIFT;
                        crv_next.ay = start_y >>> AUTO_SHIFT;
                        crv_next.bx = ctrl_x >>> AUTO_SHIFT;
                        crv_next.by = ctrl_y >>> AUTO_SHIFT;
                        crv_next.cx = end_x >>> AUTO_SHIFT;
                        crv_next.cy = end_y >>> AUTO_SHIFT;
                        st_next     = F_DD;
                    end
                    else
                    begin
                        crv_next.ax = start_x;
                        crv_next.ay = start_y;
                        crv_next.bx = ctrl_x;
                        crv_next.by = ctrl_y;
                        crv_next.cx = end_x;
                        crv_next.cy = end_y;
                        if (fl_mag == '0)
                            lvl_next = LVL_W'(1);
                        else if (fl_mag > MAX_LVL)
                            lvl_next = MAX_LVL;
                        else
                            lvl_next = fl_mag;
                        st_next = F_PUSH;
                    end
                end
            end
            F_DD:
            begin
                // second difference per axis, wrapping
                ddx_next = crv_reg.ax - crv_reg.bx - crv_reg.bx + crv_reg.cx;
                ddy_next = crv_reg.ay - crv_reg.by - crv_reg.by + crv_reg.cy;
                st_next  = F_MEAS;
            end
            F_MEAS:
            begin
                meas_next = mx + ((mx > my) ? (mx + my) : (my + my));
                st_next   = F_LVL;
            end
            F_LVL:
            begin
                // level rises once per quartering while above the limit
                lvl_next = LVL_W'(1);
                for (int k = 0; k < MAX_LEVEL - 1; k++)
                begin
                    if ((meas_reg >> (2 * k)) > FLAT_LIMIT)
                        lvl_next = LVL_W'(k + 2);
                end
                st_next = F_CNT;
            end
            F_CNT:
            begin
                count_next = sum[COUNT_W] ? {COUNT_W{1'b1}} : sum[COUNT_W-1:0];
                ovf_next   = (sum > {1'b0, cap_reg});
                st_next    = F_PUSH;
            end
            F_PUSH:
            begin
                if (job_ready)
                    st_next = F_IDLE;
            end
            default:
            begin
                st_next = F_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= F_IDLE;
            count_reg <= '0;
            cap_reg   <= CAP_RESET;
        end
        else
        begin
            st_reg    <= st_next;
            count_reg <= count_next;
            if (cfg_we)
                cap_reg <= cfg_wdata;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        crv_reg  <= crv_next;
        lvl_reg  <= lvl_next;
        ovf_reg  <= ovf_next;
        ddx_reg  <= ddx_next;
        ddy_reg  <= ddy_next;
        meas_reg <= meas_next;
    end

    // a pushed level is always within range
    a_lvl_range: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid |-> (lvl_reg >= LVL_W'(1) && lvl_reg <= MAX_LVL))
        else $error("front level out of range");

endmodule

FILE: hw/rtl/qcf_queue.sv
// qcf_queue: short job queue between front and back
// depends on qcf_pkg

module qcf_queue #(
    parameter int DEPTH = qcf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  qcf_pkg::job_t wr_job,
    output logic          rd_valid,
    input  logic          rd_ready,
    output qcf_pkg::job_t rd_job
);
    import qcf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    job_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             push, pop;

    assign wr_ready = (cnt_reg != CNT_W'(DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_job   = mem[rd_ptr_reg];

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            if (push && !pop)
                cnt_reg <= cnt_reg + CNT_W'(1);
            else if (pop && !push)
                cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_job;
    end

endmodule

FILE: hw/rtl/qcf_back.sv
// qcf_back: splits curves into half-curves and runs forward differencing
// depends on qcf_pkg

module qcf_back #(
    parameter int MAX_LEVEL  = qcf_pkg::MAX_LEVEL_DEF,
    parameter int LEAF_LEVEL = qcf_pkg::LEAF_LEVEL_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                job_valid,
    output logic                                job_ready,
    input  qcf_pkg::job_t                       job,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [qcf_pkg::POINT_W-1:0]  point_x,
    output logic signed [qcf_pkg::POINT_W-1:0]  point_y,
    output logic                                overflow,
    output logic                                last
);
    import qcf_pkg::*;

    localparam logic [2:0] B_IDLE  = 3'd0;
    localparam logic [2:0] B_CURVE = 3'd1;
    localparam logic [2:0] B_SETUP = 3'd2;
    localparam logic [2:0] B_RUN   = 3'd3;
    localparam logic [2:0] B_POP   = 3'd4;
    localparam logic [2:0] B_LOAD  = 3'd5;
    localparam logic [2:0] B_OVF   = 3'd6;

    localparam int SP_W  = $clog2(MAX_LEVEL + 1);
    localparam int IDX_W = (MAX_LEVEL > 1) ? $clog2(MAX_LEVEL) : 1;
    localparam logic [LVL_W-1:0] LEAF_LVL = LVL_W'(LEAF_LEVEL);

    logic [2:0]        st_reg, st_next;
    curve_t            cur_reg, cur_next;
    logic [LVL_W-1:0]  lvl_reg, lvl_next;
    logic [SP_W-1:0]   sp_reg, sp_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [31:0]       dx_reg, dy_reg, ddx_reg, ddy_reg;
    logic [31:0]       accx_reg, accx_next, accy_reg, accy_next;
    logic [31:0]       fdx_reg, fdx_next, fdy_reg, fdy_next;
    logic [31:0]       sdx_reg, sdx_next, sdy_reg, sdy_next;

    // half-curve stack
    job_t              stack_mem [MAX_LEVEL];
    job_t              stk_rd_reg;
    job_t              push_entry;
    logic              stk_push, stk_pop;
    logic [IDX_W-1:0]  wr_idx, rd_idx;

    // point stage and output stage
    logic               pt_valid_reg, pt_valid_next;
    logic [31:0]        ptx_reg, ptx_next, pty_reg, pty_next;
    logic [SHIFT_W-1:0] pt_sh_reg, pt_sh_next;
    logic               pt_last_reg, pt_last_next, pt_ovf_reg, pt_ovf_next;
    logic               out_valid_reg;
    logic [POINT_W-1:0] outx_reg, outy_reg;
    logic               out_ovf_reg, out_last_reg;
    logic               pt_take, s1_free;

    logic               split;
    logic [SHIFT_W-1:0] sh;
    logic [STEP_W-1:0]  step_end;
    logic [32:0]        m1x, m1y, m3x, m3y;
    logic [33:0]        m2x, m2y;
    logic [31:0]        gx, gy, rx, ry;

    assign split    = (lvl_reg > LEAF_LVL) && (lvl_reg > LVL_W'(1));
    assign sh       = {lvl_reg, 1'b0};
    assign step_end = (STEP_W'(1) << lvl_reg) - STEP_W'(1);
    assign pt_take  = pt_valid_reg && (!out_valid_reg || out_ready);
    assign s1_free  = !pt_valid_reg || pt_take;
    assign job_ready = (st_reg == B_IDLE);

    // rounded half-curve control points, full width then floor shift
    assign m1x = {cur_reg.ax[31], cur_reg.ax} + {cur_reg.bx[31], cur_reg.bx} + 33'd1;
    assign m1y = {cur_reg.ay[31], cur_reg.ay} + {cur_reg.by[31], cur_reg.by} + 33'd1;
    assign m3x = {cur_reg.cx[31], cur_reg.cx} + {cur_reg.bx[31], cur_reg.bx} + 33'd1;
    assign m3y = {cur_reg.cy[31], cur_reg.cy} + {cur_reg.by[31], cur_reg.by} + 33'd1;
    assign m2x = {{2{cur_reg.ax[31]}}, cur_reg.ax} + {cur_reg.bx[31], cur_reg.bx, 1'b0}
               + {{2{cur_reg.cx[31]}}, cur_reg.cx} + 34'd2;
    assign m2y = {{2{cur_reg.ay[31]}}, cur_reg.ay} + {cur_reg.by[31], cur_reg.by, 1'b0}
               + {{2{cur_reg.cy[31]}}, cur_reg.cy} + 34'd2;

    // second half is kept for later
    always_comb
    begin
        push_entry.crv.ax = m2x[33:2];
        push_entry.crv.ay = m2y[33:2];
        push_entry.crv.bx = m3x[32:1];
        push_entry.crv.by = m3y[32:1];
        push_entry.crv.cx = cur_reg.cx;
        push_entry.crv.cy = cur_reg.cy;
        push_entry.lvl    = lvl_reg - LVL_W'(1);
        push_entry.ovf    = 1'b0;
    end

    assign stk_push = (st_reg == B_CURVE) && split;
    assign stk_pop  = (st_reg == B_POP);
    assign wr_idx   = IDX_W'(sp_reg);
    assign rd_idx   = IDX_W'(sp_reg - SP_W'(1));

    // sequencer: split, set up leaf, step, pop, or give out an overflow item
    always_comb
    begin
        st_next       = st_reg;
        cur_next      = cur_reg;
        lvl_next      = lvl_reg;
        sp_next       = sp_reg;
        step_next     = step_reg;
        accx_next     = accx_reg;
        accy_next     = accy_reg;
        fdx_next      = fdx_reg;
        fdy_next      = fdy_reg;
        sdx_next      = sdx_reg;
        sdy_next      = sdy_reg;
        pt_valid_next = pt_take ? 1'b0 : pt_valid_reg;
        ptx_next      = ptx_reg;
        pty_next      = pty_reg;
        pt_sh_next    = pt_sh_reg;
        pt_last_next  = pt_last_reg;
        pt_ovf_next   = pt_ovf_reg;
        case (st_reg)
            B_IDLE:
            begin
                if (job_valid)
                begin
                    cur_next = job.crv;
                    lvl_next = job.lvl;
                    sp_next  = '0;
                    st_next  = job.ovf ? B_OVF : B_CURVE;
                end
            end
            B_CURVE:
            begin
                if (split)
                begin
                    cur_next.bx = m1x[32:1];
                    cur_next.by = m1y[32:1];
                    cur_next.cx = m2x[33:2];
                    cur_next.cy = m2y[33:2];
                    lvl_next    = lvl_reg - LVL_W'(1);
                    sp_next     = sp_reg + SP_W'(1);
                end
                else
                begin
                    // accumulator carries the rounding half from the start
                    accx_next = (32'(cur_reg.ax) << sh) + (32'd1 << (sh - SHIFT_W'(1)));
                    accy_next = (32'(cur_reg.ay) << sh) + (32'd1 << (sh - SHIFT_W'(1)));
                    step_next = '0;
                    st_next   = B_SETUP;
                end
            end
            B_SETUP:
            begin
                fdx_next = ddx_reg - (dx_reg << (lvl_reg + LVL_W'(1)));
                fdy_next = ddy_reg - (dy_reg << (lvl_reg + LVL_W'(1)));
                sdx_next = ddx_reg << 1;
                sdy_next = ddy_reg << 1;
                st_next  = B_RUN;
            end
            B_RUN:
            begin
                if (s1_free)
                begin
                    accx_next     = accx_reg + fdx_reg;
                    accy_next     = accy_reg + fdy_reg;
                    fdx_next      = fdx_reg + sdx_reg;
                    fdy_next      = fdy_reg + sdy_reg;
                    pt_valid_next = 1'b1;
                    ptx_next      = accx_reg + fdx_reg;
                    pty_next      = accy_reg + fdy_reg;
                    pt_sh_next    = sh;
                    pt_ovf_next   = 1'b0;
                    pt_last_next  = (step_reg == step_end) && (sp_reg == '0);
                    step_next     = step_reg + STEP_W'(1);
                    if (step_reg == step_end)
                        st_next = (sp_reg == '0) ? B_IDLE : B_POP;
                end
            end
            B_POP:
            begin
                sp_next = sp_reg - SP_W'(1);
                st_next = B_LOAD;
            end
            B_LOAD:
            begin
                cur_next = stk_rd_reg.crv;
                lvl_next = stk_rd_reg.lvl;
                st_next  = B_CURVE;
            end
            B_OVF:
            begin
                if (s1_free)
                begin
                    pt_valid_next = 1'b1;
                    ptx_next      = '0;
                    pty_next      = '0;
                    pt_sh_next    = '0;
                    pt_ovf_next   = 1'b1;
                    pt_last_next  = 1'b1;
                    st_next       = B_IDLE;
                end
            end
            default:
            begin
                st_next = B_IDLE;
            end
        endcase
    end

    // point to output conversion: rounding shifts
    assign gx = $signed(ptx_reg) >>> pt_sh_reg;
    assign gy = $signed(pty_reg) >>> pt_sh_reg;
    assign rx = $signed(gx + ROUND_ADD) >>> OUT_SHIFT;
    assign ry = $signed(gy + ROUND_ADD) >>> OUT_SHIFT;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= B_IDLE;
            sp_reg        <= '0;
            step_reg      <= '0;
            pt_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg       <= st_next;
            sp_reg       <= sp_next;
            step_reg     <= step_next;
            pt_valid_reg <= pt_valid_next;
            if (pt_take)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        lvl_reg     <= lvl_next;
        accx_reg    <= accx_next;
        accy_reg    <= accy_next;
        fdx_reg     <= fdx_next;
        fdy_reg     <= fdy_next;
        sdx_reg     <= sdx_next;
        sdy_reg     <= sdy_next;
        ptx_reg     <= ptx_next;
        pty_reg     <= pty_next;
        pt_sh_reg   <= pt_sh_next;
        pt_last_reg <= pt_last_next;
        pt_ovf_reg  <= pt_ovf_next;
        // leaf differences
        dx_reg  <= cur_reg.ax - cur_reg.bx;
        dy_reg  <= cur_reg.ay - cur_reg.by;
        ddx_reg <= cur_reg.ax - cur_reg.bx - cur_reg.bx + cur_reg.cx;
        ddy_reg <= cur_reg.ay - cur_reg.by - cur_reg.by + cur_reg.cy;
        if (pt_take)
        begin
            outx_reg     <= rx[POINT_W-1:0];
            outy_reg     <= ry[POINT_W-1:0];
            out_ovf_reg  <= pt_ovf_reg;
            out_last_reg <= pt_last_reg;
        end
    end

    // stack memory
    always_ff @(posedge clk)
    begin
        if (stk_push)
            stack_mem[wr_idx] <= push_entry;
        if (stk_pop)
            stk_rd_reg <= stack_mem[rd_idx];
    end

    assign out_valid = out_valid_reg;
    assign point_x   = outx_reg;
    assign point_y   = outy_reg;
    assign overflow  = out_ovf_reg;
    assign last      = out_last_reg;

    // stack never grows past its depth
    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stk_push |-> (sp_reg < SP_W'(MAX_LEVEL)))
        else $error("half-curve stack overrun");

    // stepping only ever runs on a leaf-sized curve
    a_leaf_level: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == B_RUN) |-> !split)
        else $error("stepping a curve above leaf level");

    // an overflow item is always the final item of its curve
    a_ovf_last: assert property (@(posedge clk) disable iff (!rst_n)
        (pt_valid_reg && pt_ovf_reg) |-> pt_last_reg)
        else $error("overflow item without last");

    // a pop only happens with something on the stack
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        stk_pop |-> (sp_reg != '0))
        else $error("pop from empty stack");

endmodule

FILE: hw/rtl/quadratic_curve_flattener_unit.sv
// quadratic curve flattener: one curve in, 2^level polyline points out, or one overflow item
// the front takes a new curve only after its last job is handed to the queue; automatic
//   curves pass through difference, measure, level and count states, forced ones do not
// throughput: the back gives one point per cycle while stepping, unless the output is
//   held off
// reset: asynchronous, count cleared, capacity 257, no item in flight
// depends on qcf_pkg, qcf_front, qcf_queue, qcf_back

module quadratic_curve_flattener_unit #(
    parameter int MAX_LEVEL   = qcf_pkg::MAX_LEVEL_DEF,
    parameter int LEAF_LEVEL  = qcf_pkg::LEAF_LEVEL_DEF,
    parameter int QUEUE_DEPTH = qcf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [qcf_pkg::COORD_W-1:0]  start_x,
    input  logic signed [qcf_pkg::COORD_W-1:0]  start_y,
    input  logic signed [qcf_pkg::COORD_W-1:0]  ctrl_x,
    input  logic signed [qcf_pkg::COORD_W-1:0]  ctrl_y,
    input  logic signed [qcf_pkg::COORD_W-1:0]  end_x,
    input  logic signed [qcf_pkg::COORD_W-1:0]  end_y,
    input  logic signed [qcf_pkg::FIXED_W-1:0]  fixed_level,
    input  logic                                clear_count,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [qcf_pkg::POINT_W-1:0]  point_x,
    output logic signed [qcf_pkg::POINT_W-1:0]  point_y,
    output logic                                overflow,
    output logic                                last,
    input  logic                                cfg_we,
    input  logic [qcf_pkg::COUNT_W-1:0]         cfg_wdata
);
    import qcf_pkg::*;

    logic f_valid, f_ready, b_valid, b_ready;
    job_t f_job, b_job;

    // level selection and count check
    qcf_front #(
        .MAX_LEVEL (MAX_LEVEL)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .start_x     (start_x),
        .start_y     (start_y),
        .ctrl_x      (ctrl_x),
        .ctrl_y      (ctrl_y),
        .end_x       (end_x),
        .end_y       (end_y),
        .fixed_level (fixed_level),
        .clear_count (clear_count),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .job_valid   (f_valid),
        .job_ready   (f_ready),
        .job         (f_job)
    );

    // decoupling queue
    qcf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_job   (f_job),
        .rd_valid (b_valid),
        .rd_ready (b_ready),
        .rd_job   (b_job)
    );

    // subdivision and forward differencing
    qcf_back #(
        .MAX_LEVEL  (MAX_LEVEL),
        .LEAF_LEVEL (LEAF_LEVEL)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (b_valid),
        .job_ready (b_ready),
        .job       (b_job),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .point_x   (point_x),
        .point_y   (point_y),
        .overflow  (overflow),
        .last      (last)
    );

endmodule

FILE: tb/qcf_checker.sv
`timescale 1ns / 100ps
// qcf_checker: predicts the polyline points of each accepted curve and compares them
// with the points the flattener gives out; depends on qcf_pkg

module qcf_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic signed [qcf_pkg::COORD_W-1:0]  start_x,
    input  logic signed [qcf_pkg::COORD_W-1:0]  start_y,
    input  logic signed [qcf_pkg::COORD_W-1:0]  ctrl_x,
    input  logic signed [qcf_pkg::COORD_W-1:0]  ctrl_y,
    input  logic signed [qcf_pkg::COORD_W-1:0]  end_x,
    input  logic signed [qcf_pkg::COORD_W-1:0]  end_y,
    input  logic signed [qcf_pkg::FIXED_W-1:0]  fixed_level,
    input  logic                                clear_count,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic signed [qcf_pkg::POINT_W-1:0]  point_x,
    input  logic signed [qcf_pkg::POINT_W-1:0]  point_y,
    input  logic                                overflow,
    input  logic                                last,
    input  logic                                cfg_we,
    input  logic [qcf_pkg::COUNT_W-1:0]         cfg_wdata,
    output int                                  fail_count,
    output int                                  pending
);
    import qcf_pkg::*;

    localparam int MAX_LVL  = MAX_LEVEL_DEF;
    localparam int LEAF_LVL = LEAF_LEVEL_DEF;

    typedef struct packed {
        logic [POINT_W-1:0] px;
        logic [POINT_W-1:0] py;
        logic               ovf;
        logic               lst;
    } point_t;

    point_t      point_queue[$];
    logic [15:0] capacity;
    logic [31:0] vec_count;

    initial fail_count = 0;
    assign pending = point_queue.size();

    // arithmetic right shift on a 32-bit word
    function automatic logic [31:0] sra32(logic [31:0] v, int s);
        return $signed(v) >>> s;
    endfunction

    // forward-difference one leaf curve on both axes
    task automatic step_leaf(logic [31:0] a[2], logic [31:0] b[2], logic [31:0] c[2], int n);
        logic [31:0] acc[2], d1[2], d2[2], d, dd, g, p[2];
        int sh;
        sh = 2 * n;
        for (int ax = 0; ax < 2; ax++)
        begin
            d = a[ax] - b[ax];
            dd = d - b[ax] + c[ax];
            d1[ax] = dd - (d << (n + 1));
            d2[ax] = dd + dd;
            acc[ax] = a[ax] << sh;
        end
        for (int k = 0; k < (1 << n); k++)
        begin
            for (int ax = 0; ax < 2; ax++)
            begin
                acc[ax] += d1[ax];
                g = sra32(acc[ax] + (32'd1 << (sh - 1)), sh);
                g = sra32(g + 32'd3, 3);
                p[ax] = sra32(g, 3);
                d1[ax] += d2[ax];
            end
            point_queue.push_back('{p[0][POINT_W-1:0], p[1][POINT_W-1:0], 1'b0, 1'b0});
        end
    endtask

    // split into rounded halves above the leaf level
    task automatic split_curve(logic [31:0] a[2], logic [31:0] b[2], logic [31:0] c[2], int n);
        logic [31:0] m1[2], m2[2], m3[2];
        logic signed [63:0] wa, wb, wc;
        if (n <= LEAF_LVL)
        begin
            step_leaf(a, b, c, n);
            return;
        end
        for (int ax = 0; ax < 2; ax++)
        begin
            wa = $signed(a[ax]);
            wb = $signed(b[ax]);
            wc = $signed(c[ax]);
            m1[ax] = 32'((wa + wb + 1) >>> 1);
            m2[ax] = 32'((wa + wb + wb + wc + 2) >>> 2);
            m3[ax] = 32'((wc + wb + 1) >>> 1);
        end
        split_curve(a, m1, m2, n - 1);
        split_curve(m2, m3, c, n - 1);
    endtask

    // expected points of one accepted curve
    task automatic predict_curve();
        logic [31:0] a[2], b[2], c[2], ddx, ddy, mx, my, meas, sum;
        int n, first;
        first = point_queue.size();
        if (clear_count) vec_count = 0;
        a[0] = start_x; a[1] = start_y;
        b[0] = ctrl_x;  b[1] = ctrl_y;
        c[0] = end_x;   c[1] = end_y;
        if (fixed_level[3])
        begin
            for (int ax = 0; ax < 2; ax++)
            begin
                a[ax] = sra32(a[ax], 10);
                b[ax] = sra32(b[ax], 10);
                c[ax] = sra32(c[ax], 10);
            end
            ddx = a[0] - b[0] - b[0] + c[0];
            ddy = a[1] - b[1] - b[1] + c[1];
            mx = ddx[31] ? -ddx : ddx;
            my = ddy[31] ? -ddy : ddy;
            meas = mx + ((mx > my) ? mx + my : my + my);
            n = 1;
            while (meas > 32'd128)
            begin
                n++;
                meas >>= 2;
            end
            if (n > MAX_LVL) n = MAX_LVL;
            sum = vec_count + (32'd1 << n);
            vec_count = (sum > 32'hFFFF) ? 32'hFFFF : sum;
            if (sum > capacity)
            begin
                point_queue.push_back('{'0, '0, 1'b1, 1'b1});
                return;
            end
        end
        else
        begin
            n = (fixed_level == 0) ? 1 : int'(fixed_level);
            if (n > MAX_LVL) n = MAX_LVL;
        end
        split_curve(a, b, c, n);
        if (point_queue.size() > first) point_queue[$].lst = 1'b1;
    endtask

    // watch both channels and the configuration port
    always @(posedge clk or negedge rst_n)
    begin
        point_t want;
        if (!rst_n)
        begin
            capacity = 16'd257;
            vec_count = 0;
            point_queue.delete();
        end
        else
        begin
            if (cfg_we) capacity = cfg_wdata;
            if (in_valid && in_ready) predict_curve();
            if (out_valid && out_ready)
            begin
                if (point_queue.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected point x=%0d y=%0d ovf=%0b last=%0b",
                             $time, point_x, point_y, overflow, last);
                end
                else
                begin
                    want = point_queue.pop_front();
                    if (point_x !== want.px || point_y !== want.py ||
                        overflow !== want.ovf || last !== want.lst)
                    begin
                        fail_count++;
                        $display("%0t: expected %0d,%0d,%0b,%0b got %0d,%0d,%0b,%0b",
                                 $time, $signed(want.px), $signed(want.py), want.ovf,
                                 want.lst, point_x, point_y, overflow, last);
                    end
                end
            end
        end
    end
endmodule

FILE: tb/tb_quadratic_curve_flattener_unit.sv
`timescale 1ns / 100ps
// tb_quadratic_curve_flattener_unit: drives curves and capacity settings into the flattener
// and gives the verdict; depends on qcf_pkg, qcf_checker and the flattener rtl

module tb_quadratic_curve_flattener_unit;
    import qcf_pkg::*;

    logic clk, rst_n;
    logic in_valid, in_ready, out_valid, out_ready;
    logic signed [COORD_W-1:0] start_x, start_y, ctrl_x, ctrl_y, end_x, end_y;
    logic signed [FIXED_W-1:0] fixed_level;
    logic clear_count, overflow, last, cfg_we;
    logic signed [POINT_W-1:0] point_x, point_y;
    logic [COUNT_W-1:0] cfg_wdata;
    int fail_count, pending;
    int hold_cycles;
    bit calm;
    int idle_cycles;

    quadratic_curve_flattener_unit dut (.*);
    qcf_checker checker_i (.*);

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    // receiver: random stall bursts, one long hold-off on request
    initial
    begin
        out_ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_ready <= 0;
                hold_cycles--;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 0;
                repeat ($urandom_range(1, 3) - 1) @(negedge clk);
            end
            else
                out_ready <= 1;
        end
    end

    // watchdog on cycles with no accepted item
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || hold_cycles > 0)
            idle_cycles = 0;
        else if (++idle_cycles > 20000)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom;
            default: return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
        endcase
    endfunction

    // valid stays high from one item to the next unless an idle burst comes first
    task automatic send_curve(logic [31:0] ax, ay, bx, by, cx, cy, logic [3:0] lvl,
                              logic clr);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        start_x <= ax; start_y <= ay; ctrl_x <= bx; ctrl_y <= by;
        end_x <= cx; end_y <= cy; fixed_level <= lvl; clear_count <= clr;
        in_valid <= 1;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic send_random();
        logic [3:0] lvl;
        case ($urandom_range(0, 3))
            0, 1: lvl = 4'hF;
            2: lvl = 4'($urandom_range(0, 6));
            default: lvl = 4'($urandom);
        endcase
        send_curve(pick_coord(), pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                   pick_coord(), lvl, $urandom_range(0, 3) == 0);
    endtask

    task automatic drain_and_write(logic [15:0] cap);
        in_valid <= 0;
        while (pending != 0) @(negedge clk);
        repeat (100) @(negedge clk);
        cfg_wdata <= cap;
        cfg_we <= 1;
        @(negedge clk);
        cfg_we <= 0;
    endtask

    initial
    begin
        rst_n = 0;
        in_valid = 0; cfg_we = 0; cfg_wdata = 0; clear_count = 0;
        start_x = 0; start_y = 0; ctrl_x = 0; ctrl_y = 0; end_x = 0; end_y = 0;
        fixed_level = 0; hold_cycles = 0; calm = 0; idle_cycles = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // directed: every level, extremes, automatic and overflow cases
        for (int l = 0; l <= 7; l++)
            send_curve(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                       32'h8000_0000, 32'h7FFF_FFFF, 4'(l), 1'b0);
        send_curve(0, 0, 0, 0, 0, 0, 4'hF, 1'b1);
        send_curve(32'h0010_0000, 0, 32'h0500_0000, 32'h0300_0000, 0, 32'h0010_0000,
                   4'hF, 1'b0);
        send_curve(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'h8000_0000, 32'h8000_0000, 4'hF, 1'b0);
        for (int i = 0; i < 6; i++)
            send_curve(0, 0, 32'h4000_0000, 32'h4000_0000, 0, 0, 4'hF, 1'b0);
        send_curve(32'hFFFF_FFFF, 32'h1234_5678, 32'h0, 32'h8765_4321, 32'h7, 32'h0,
                   4'h9, 1'b1);
        send_curve(32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555,
                   32'h0F0F_0F0F, 32'hF0F0_F0F0, 4'h6, 1'b0);

        // capacity extremes
        drain_and_write(16'd0);
        for (int i = 0; i < 4; i++) send_random();
        drain_and_write(16'hFFFF);
        for (int i = 0; i < 60; i++) send_random();
        drain_and_write(16'd1);
        for (int i = 0; i < 10; i++) send_random();
        drain_and_write(16'd600);

        // long receiver hold-off while curves keep coming
        hold_cycles = 400;
        for (int i = 0; i < 10; i++) send_random();
        for (int i = 0; i < 220; i++) send_random();
        drain_and_write(16'd257);
        for (int i = 0; i < 40; i++) send_random();

        // last part with no idling
        calm = 1;
        for (int i = 0; i < 30; i++) send_random();

        in_valid <= 0;
        while (pending != 0) @(negedge clk);
        repeat (100) @(negedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
